@@ hdl/chb_pkg.sv @@
// Package for the case-folded byte hash: lane and request types, constants,
// and the per-step mix/final functions used by the back module.
// No dependencies.
package chb_pkg;

	localparam logic [31:0] HASH_INIT   = 32'hdeadbeef;
	localparam logic [31:0] SEED_RESET  = 32'd42;
	localparam logic        FOLD_RESET  = 1'b1;
	localparam logic [3:0]  BLOCK_BYTES = 4'd12;
	localparam logic [2:0]  MIX_STEPS   = 3'd6;
	localparam int          FIN_STEPS   = 7;
	localparam int          QUEUE_DEPTH = 4;
	localparam int          QPTR_W      = 2;

	// register indexes (paddr[2])
	localparam logic REG_SEED = 1'b0;
	localparam logic REG_FOLD = 1'b1;

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
	} lanes_t;

	// one request from front to back
	typedef struct packed {
		logic        init;   // new key, load start value
		logic [31:0] start;
		logic        add;    // a byte is taken
		logic [7:0]  data;
		logic [3:0]  pos;    // slot within the 12-byte block
		logic        trig;   // previous block is full: mix before adding
		logic        fin;    // last item, emit a hash
		logic        raw;    // no byte taken: emit lane c untouched
	} chb_op_t;

	function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned r);
		return (x << r) | (x >> (32 - r));
	endfunction

	function automatic lanes_t add_lanes(input lanes_t x, input lanes_t y);
		lanes_t r;
		r.a = x.a + y.a;
		r.b = x.b + y.b;
		r.c = x.c + y.c;
		return r;
	endfunction

	function automatic logic [7:0] fold_byte(input logic [7:0] d, input logic fold);
		if (fold && d >= 8'h41 && d <= 8'h5a)
			return d + 8'h20;
		return d;
	endfunction

	// place a byte into an empty byte slot of the pending words
	function automatic lanes_t insert_byte(input lanes_t l, input logic [7:0] d,
			input logic [3:0] pos);
		lanes_t      r;
		logic [31:0] w;
		r = l;
		w = 32'(d) << {pos[1:0], 3'b000};
		if (pos < 4'd4)
			r.a = l.a | w;
		else if (pos < 4'd8)
			r.b = l.b | w;
		else
			r.c = l.c | w;
		return r;
	endfunction

	// one of the six rounds of the block mix
	function automatic lanes_t mix_step(input lanes_t l, input logic [2:0] k);
		lanes_t r;
		r = l;
		case (k)
			3'd0: begin
				r.a = (l.a - l.c) ^ rotl(l.c, 4);
				r.c = l.c + l.b;
			end
			3'd1: begin
				r.b = (l.b - l.a) ^ rotl(l.a, 6);
				r.a = l.a + l.c;
			end
			3'd2: begin
				r.c = (l.c - l.b) ^ rotl(l.b, 8);
				r.b = l.b + l.a;
			end
			3'd3: begin
				r.a = (l.a - l.c) ^ rotl(l.c, 16);
				r.c = l.c + l.b;
			end
			3'd4: begin
				r.b = (l.b - l.a) ^ rotl(l.a, 19);
				r.a = l.a + l.c;
			end
			3'd5: begin
				r.c = (l.c - l.b) ^ rotl(l.b, 4);
				r.b = l.b + l.a;
			end
			default: r = l;
		endcase
		return r;
	endfunction

	// one of the seven rounds of the final avalanche
	function automatic lanes_t final_step(input lanes_t l, input logic [2:0] k);
		lanes_t r;
		r = l;
		case (k)
			3'd0: r.c = (l.c ^ l.b) - rotl(l.b, 14);
			3'd1: r.a = (l.a ^ l.c) - rotl(l.c, 11);
			3'd2: r.b = (l.b ^ l.a) - rotl(l.a, 25);
			3'd3: r.c = (l.c ^ l.b) - rotl(l.b, 16);
			3'd4: r.a = (l.a ^ l.c) - rotl(l.c, 4);
			3'd5: r.b = (l.b ^ l.a) - rotl(l.a, 14);
			3'd6: r.c = (l.c ^ l.b) - rotl(l.b, 24);
			default: r = l;
		endcase
		return r;
	endfunction

endpackage

@@ hdl/chb_if.sv @@
// Valid/ready channel interfaces for key bytes in and hash results out.
// No dependencies.
interface chb_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic [8:0] key_length;
	logic       first_item;
	logic       last_item;

	modport source (output valid, data_byte, key_length, first_item, last_item,
		input ready);
	modport sink (input valid, data_byte, key_length, first_item, last_item,
		output ready);
endinterface

interface chb_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] hash_value;

	modport source (output valid, hash_value, input ready);
	modport sink (input valid, hash_value, output ready);
endinterface

@@ hdl/case_folded_byte_hash.sv @@
// Case-folded byte hash, top level: configuration registers, front end,
// request queue and back end. Uses chb_pkg, chb_if, chb_front, chb_queue, chb_back.
// Throughput: one byte per cycle unless the request queue is full; a block mix runs
// beside byte packing.
// A key that ends right after a mix waits for it; the mix round unit sets that.
// Reset: arst_n clears lanes, counters and valids at once; no clearing pass.
module case_folded_byte_hash import chb_pkg::*; #(
	parameter int MAX_KEY_BYTES = 511
) (
	input  logic        clk,
	input  logic        arst_n,
	chb_in_if.sink      key_in,
	chb_out_if.source   hash_out,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [31:0] seed_q, base_q;
	logic        fold_q;
	logic        cfg_wr;

	chb_op_t front_op, head_op;
	logic    front_valid, q_not_full, head_valid, head_pop;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= SEED_RESET;
			base_q <= HASH_INIT + SEED_RESET;
			fold_q <= FOLD_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_SEED: begin
					seed_q <= pwdata;
					base_q <= HASH_INIT + pwdata;
				end
				REG_FOLD: fold_q <= pwdata[0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_SEED: prdata = seed_q;
			REG_FOLD: prdata = {31'd0, fold_q};
		endcase
	end

	chb_front #(
		.MAX_KEY_BYTES(MAX_KEY_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.key_in    (key_in),
		.seed_base (base_q),
		.fold_case (fold_q),
		.op        (front_op),
		.op_valid  (front_valid),
		.op_ready  (q_not_full)
	);

	chb_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_op    (front_op),
		.push       (front_valid),
		.not_full   (q_not_full),
		.head_op    (head_op),
		.head_valid (head_valid),
		.pop        (head_pop)
	);

	chb_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (head_op),
		.op_valid (head_valid),
		.op_pop   (head_pop),
		.hash_out (hash_out)
	);

endmodule

@@ hdl/chb_front.sv @@
// Front end: accepts key bytes, tracks block position and byte count,
// and turns each item into at most one request for the back end. Uses chb_pkg, chb_if.
module chb_front import chb_pkg::*; #(
	parameter int MAX_KEY_BYTES = 511
) (
	input  logic        clk,
	input  logic        arst_n,
	chb_in_if.sink      key_in,
	input  logic [31:0] seed_base,
	input  logic        fold_case,
	output chb_op_t     op,
	output logic        op_valid,
	input  logic        op_ready
);

	localparam int              CNT_W   = $clog2(MAX_KEY_BYTES + 1);
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_KEY_BYTES);
	localparam logic [31:0]     MAX_W   = 32'(MAX_KEY_BYTES);

	logic [CNT_W-1:0] taken_q, taken_cur, taken_n;
	logic [3:0]       pos_q, pos_cur, pos_inc, pos_n;
	logic             full_q, full_cur, full_n;
	logic [31:0]      len_w, len_lim;
	logic             skip, take, acc;

	assign key_in.ready = op_ready;
	assign acc = key_in.valid && op_ready;

	always_comb begin
		len_w   = 32'(key_in.key_length);
		len_lim = (len_w > MAX_W) ? MAX_W : len_w;

		taken_cur = key_in.first_item ? '0 : taken_q;
		pos_cur   = key_in.first_item ? '0 : pos_q;
		full_cur  = key_in.first_item ? 1'b0 : full_q;

		skip = key_in.first_item && (key_in.key_length == '0);
		take = !skip && (taken_cur < MAX_CNT);

		pos_inc = pos_cur + 4'd1;
		if (take) begin
			taken_n = taken_cur + CNT_W'(1);
			if (pos_inc == BLOCK_BYTES) begin
				pos_n  = '0;
				full_n = 1'b1;
			end else begin
				pos_n  = pos_inc;
				full_n = 1'b0;
			end
		end else begin
			taken_n = taken_cur;
			pos_n   = pos_cur;
			full_n  = full_cur;
		end

		op.init  = key_in.first_item;
		op.start = seed_base + len_lim;
		op.add   = take;
		op.data  = fold_byte(key_in.data_byte, fold_case);
		op.pos   = pos_cur;
		op.trig  = take && full_cur;
		op.fin   = key_in.last_item;
		op.raw   = (taken_n == '0);
	end

	// items that neither start, take a byte nor finish leave no request
	assign op_valid = key_in.valid && (key_in.first_item || take || key_in.last_item);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taken_q <= '0;
			pos_q   <= '0;
			full_q  <= 1'b0;
		end else if (acc) begin
			taken_q <= taken_n;
			pos_q   <= pos_n;
			full_q  <= full_n;
		end
	end

endmodule

@@ hdl/chb_queue.sv @@
// Small request queue between front and back end, register based.
// Uses chb_pkg.
module chb_queue import chb_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  chb_op_t push_op,
	input  logic    push,
	output logic    not_full,
	output chb_op_t head_op,
	output logic    head_valid,
	input  logic    pop
);

	chb_op_t           ent_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   cnt_q;
	logic              do_push, do_pop;

	assign not_full   = (cnt_q != (QPTR_W+1)'(QUEUE_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_op    = ent_q[rd_ptr_q];
	assign do_push    = push && not_full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push)
			ent_q[wr_ptr_q] <= push_op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (do_push && !do_pop)
				cnt_q <= cnt_q + (QPTR_W+1)'(1);
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - (QPTR_W+1)'(1);
		end
	end

endmodule

@@ hdl/chb_back.sv @@
// Back end: holds the hash lanes, packs bytes, runs the six-round block mix
// one round per cycle and the final avalanche as an eight-stage pipeline.
// Uses chb_pkg, chb_if.
module chb_back import chb_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  chb_op_t op,
	input  logic    op_valid,
	output logic    op_pop,
	chb_out_if.source hash_out
);

	localparam int FIN_STAGES = FIN_STEPS + 1;

	lanes_t      lanes_q, pend_q;
	logic [2:0]  mix_cnt_q;
	logic        part_q;
	lanes_t      fin_lanes_s [1:FIN_STAGES];
	logic        fin_raw_s   [1:FIN_STAGES];
	logic        fin_vld_s   [1:FIN_STAGES];
	logic        out_v_q;
	logic [31:0] out_hash_q;

	lanes_t start_l, base, pbase, pins, lanes_n, fin_in;
	logic   busy, adv, blocked, go, split, issue_fin;

	assign busy = (mix_cnt_q != '0);
	assign adv  = !out_v_q || hash_out.ready;

	always_comb begin
		start_l = '{a: op.start, b: op.start, c: op.start};
		base    = op.init ? start_l : lanes_q;
		pbase   = op.init ? '0 : pend_q;
		pins    = op.add ? insert_byte(op.trig ? '0 : pbase, op.data, op.pos) : pbase;
		lanes_n = op.trig ? add_lanes(base, pbase) : base;
		// a last byte that also starts a mix is done in two passes:
		// the byte first, the final once the mix is through
		fin_in  = add_lanes(part_q ? lanes_q : base, part_q ? pend_q : pins);

		if (part_q)
			blocked = busy || !adv;
		else
			blocked = (busy && (op.init || op.trig || op.fin)) ||
				(op.fin && !op.trig && !adv);
		go        = op_valid && !blocked;
		split     = !part_q && op.trig && op.fin;
		issue_fin = go && (part_q || (op.fin && !op.trig));
	end

	assign op_pop = go && !split;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lanes_q   <= '0;
			pend_q    <= '0;
			mix_cnt_q <= '0;
			part_q    <= 1'b0;
		end else begin
			if (busy)
				lanes_q <= mix_step(lanes_q, MIX_STEPS - mix_cnt_q);
			else if (go && !part_q)
				lanes_q <= lanes_n;
			if (go && !part_q)
				pend_q <= pins;
			if (go && !part_q && op.trig)
				mix_cnt_q <= MIX_STEPS;
			else if (busy)
				mix_cnt_q <= mix_cnt_q - 3'd1;
			if (go && split)
				part_q <= 1'b1;
			else if (go && part_q)
				part_q <= 1'b0;
		end
	end

	// final avalanche pipeline, moves as a whole when the output slot frees
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= FIN_STAGES; i++)
				fin_vld_s[i] <= 1'b0;
			out_v_q <= 1'b0;
		end else if (adv) begin
			fin_vld_s[1] <= issue_fin;
			for (int i = 1; i < FIN_STAGES; i++)
				fin_vld_s[i+1] <= fin_vld_s[i];
			out_v_q <= fin_vld_s[FIN_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fin_lanes_s[1] <= fin_in;
			fin_raw_s[1]   <= op.raw;
			for (int i = 1; i < FIN_STAGES; i++) begin
				fin_lanes_s[i+1] <= fin_raw_s[i] ? fin_lanes_s[i] :
					final_step(fin_lanes_s[i], 3'(i - 1));
				fin_raw_s[i+1]   <= fin_raw_s[i];
			end
			out_hash_q <= fin_lanes_s[FIN_STAGES].c;
		end
	end

	assign hash_out.valid      = out_v_q;
	assign hash_out.hash_value = out_hash_q;

endmodule

@@ hdl/chb_checker.sv @@
// Port-level checks for the case-folded byte hash, bound to the top level.
// Depends on case_folded_byte_hash and its channel interfaces.
module chb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        in_last,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] out_hash
);

	logic [7:0] owed_q;   // last items accepted, hash not yet delivered
	logic       in_acc, out_acc;

	assign in_acc  = in_valid && in_ready && in_last;
	assign out_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			owed_q <= '0;
		else if (in_acc && !out_acc)
			owed_q <= owed_q + 8'd1;
		else if (out_acc && !in_acc)
			owed_q <= owed_q - 8'd1;
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("hash request dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_hash))
		else $error("hash value changed while stalled");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> owed_q != 8'd0)
		else $error("hash shown without a pending last byte");

	a_reset_idle: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("output valid during reset");

endmodule

bind case_folded_byte_hash chb_checker u_chb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (key_in.valid),
	.in_ready  (key_in.ready),
	.in_last   (key_in.last_item),
	.out_valid (hash_out.valid),
	.out_ready (hash_out.ready),
	.out_hash  (hash_out.hash_value)
);

@@ test/testbench.sv @@
// Testbench for case_folded_byte_hash: random key streams with a predictor.
// Checks each hash against the predicted value and reads back the APB registers.
// Depends on chb_pkg, chb_if and the case_folded_byte_hash RTL.
`timescale 1ns / 1ps

module testbench;
	import chb_pkg::*;

	localparam int          MAX_KEY       = 511;
	localparam int          BLOCK_LEN     = 12;
	localparam int          SETTLE_CYCLES = 40;
	localparam int          HOLD_CYCLES   = 300;
	localparam int          WATCHDOG_MAX  = 2000;
	localparam int          RAND_ITEMS    = 160;
	localparam logic [2:0]  ADDR_SEED     = {REG_SEED, 2'b00};
	localparam logic [2:0]  ADDR_FOLD     = {REG_FOLD, 2'b00};

	typedef struct {
		logic [7:0] data;
		logic [8:0] len;
		bit         first;
		bit         last;
	} key_item_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	chb_in_if  key_in();
	chb_out_if hash_out();

	case_folded_byte_hash #(.MAX_KEY_BYTES(MAX_KEY)) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.key_in  (key_in),
		.hash_out(hash_out),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #10 clk = ~clk;

	key_item_t   key_queue[$];
	logic [31:0] hash_expected[$];
	int          mismatches = 0;
	int          idle_cycles = 0;
	bit          in_acc = 1'b0;
	bit          quiet = 1'b0;
	bit          hold_req = 1'b0;
	bit          hold_seen = 1'b0;
	int          send_gap = 0;
	int          ready_wait = 0;

	// predictor state and its copy of the registers
	logic [31:0] cfg_seed;
	bit          cfg_fold;
	logic [31:0] ln_a, ln_b, ln_c;
	logic [3:0]  slot;
	int unsigned taken;
	bit          blk_full;

	function automatic logic [31:0] rol(input logic [31:0] x, input int unsigned r);
		return (x << r) | (x >> (32 - r));
	endfunction

	function automatic void lanes_mix();
		ln_a -= ln_c; ln_a ^= rol(ln_c, 4);  ln_c += ln_b;
		ln_b -= ln_a; ln_b ^= rol(ln_a, 6);  ln_a += ln_c;
		ln_c -= ln_b; ln_c ^= rol(ln_b, 8);  ln_b += ln_a;
		ln_a -= ln_c; ln_a ^= rol(ln_c, 16); ln_c += ln_b;
		ln_b -= ln_a; ln_b ^= rol(ln_a, 19); ln_a += ln_c;
		ln_c -= ln_b; ln_c ^= rol(ln_b, 4);  ln_b += ln_a;
	endfunction

	function automatic logic [31:0] lanes_final(input logic [31:0] a, input logic [31:0] b,
			input logic [31:0] c);
		c ^= b; c -= rol(b, 14);
		a ^= c; a -= rol(c, 11);
		b ^= a; b -= rol(a, 25);
		c ^= b; c -= rol(b, 16);
		a ^= c; a -= rol(c, 4);
		b ^= a; b -= rol(a, 14);
		c ^= b; c -= rol(b, 24);
		return c;
	endfunction

	function automatic void hash_take(input logic [7:0] d);
		logic [31:0] w;
		if (taken >= MAX_KEY)
			return;
		if (cfg_fold && d >= 8'h41 && d <= 8'h5a)
			d = d + 8'h20;
		if (blk_full) begin
			lanes_mix();
			blk_full = 1'b0;
			slot = 4'd0;
		end
		if (slot >= BLOCK_LEN)
			slot = 4'd0;
		w = 32'(d) << {slot[1:0], 3'b000};
		if (slot < 4)
			ln_a += w;
		else if (slot < 8)
			ln_b += w;
		else
			ln_c += w;
		slot++;
		if (slot == BLOCK_LEN) begin
			blk_full = 1'b1;
			slot = 4'd0;
		end
		taken++;
	endfunction

	// returns 1 when the item ends a key; h holds the expected hash
	function automatic bit hash_predict(input key_item_t it, output logic [31:0] h);
		logic [31:0] start;
		bit          skip;
		skip = 1'b0;
		if (it.first) begin
			start = HASH_INIT + 32'(it.len) + cfg_seed;
			ln_a = start;
			ln_b = start;
			ln_c = start;
			slot = 4'd0;
			taken = 0;
			blk_full = 1'b0;
			skip = (it.len == 0);
		end
		if (!skip)
			hash_take(it.data);
		h = (taken == 0) ? ln_c : lanes_final(ln_a, ln_b, ln_c);
		return it.last;
	endfunction

	function automatic int pick_gap();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// request driver
	always @(negedge clk) begin
		key_item_t it;
		if (key_in.valid && !in_acc) begin
			// request still pending
		end else if (send_gap > 0) begin
			key_in.valid <= 1'b0;
			send_gap--;
		end else if (key_queue.size() != 0) begin
			it = key_queue.pop_front();
			key_in.data_byte  <= it.data;
			key_in.key_length <= it.len;
			key_in.first_item <= it.first;
			key_in.last_item  <= it.last;
			key_in.valid      <= 1'b1;
			send_gap = pick_gap();
		end else begin
			key_in.valid <= 1'b0;
		end
	end

	// result ready, with random stalls and one long hold-off on request
	always @(negedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			ready_wait = HOLD_CYCLES;
		end
		if (ready_wait > 0) begin
			hash_out.ready <= 1'b0;
			ready_wait--;
		end else begin
			hash_out.ready <= 1'b1;
			if ($urandom_range(0, 3) == 0)
				ready_wait = pick_gap();
		end
	end

	// predictor, monitor and watchdog
	always @(posedge clk) begin
		key_item_t   it;
		logic [31:0] h;
		logic [31:0] want;
		bit          busy;
		busy = 1'b0;
		in_acc <= key_in.valid && key_in.ready;
		if (key_in.valid && key_in.ready) begin
			busy = 1'b1;
			it.data  = key_in.data_byte;
			it.len   = key_in.key_length;
			it.first = key_in.first_item;
			it.last  = key_in.last_item;
			if (hash_predict(it, h))
				hash_expected.push_back(h);
		end
		if (hash_out.valid && hash_out.ready) begin
			busy = 1'b1;
			if (hash_expected.size() == 0) begin
				$error("hash_value: expected none, actual %h", hash_out.hash_value);
				mismatches++;
			end else begin
				want = hash_expected.pop_front();
				if (want !== hash_out.hash_value) begin
					$error("hash_value: expected %h, actual %h", want, hash_out.hash_value);
					mismatches++;
				end
			end
		end
		idle_cycles = busy ? 0 : idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_MAX) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic push_item(input logic [7:0] d, input logic [8:0] l, input bit f,
			input bit la);
		key_item_t it;
		it.data  = d;
		it.len   = l;
		it.first = f;
		it.last  = la;
		key_queue.push_back(it);
	endtask

	function automatic logic [7:0] rand_byte();
		case ($urandom_range(0, 3))
			0: return 8'($urandom_range(8'h41, 8'h5a));
			1: return 8'($urandom_range(8'h61, 8'h7a));
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// n items; key_length on later items is noise the block must ignore
	task automatic push_key(input int n, input logic [8:0] len, input bit with_first,
			input bit stray_last);
		bit la;
		for (int i = 0; i < n; i++) begin
			la = (i == n - 1) || (stray_last && $urandom_range(0, 15) == 0);
			push_item(rand_byte(), (i == 0) ? len : 9'($urandom_range(0, 511)),
				with_first && i == 0, la);
		end
	endtask

	function automatic int pick_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 14);
		if (r < 95)
			return $urandom_range(15, 40);
		return $urandom_range(41, 120);
	endfunction

	task automatic random_keys(input int items);
		int count;
		int n;
		int r;
		count = 0;
		while (count < items) begin
			r = $urandom_range(0, 99);
			if (r < 5) begin
				n = 1;
				push_key(1, 9'd0, 1'b1, 1'b0);
			end else if (r < 85) begin
				n = pick_size();
				push_key(n, 9'(n), 1'b1, 1'b0);
			end else begin
				// broken keys: wrong length, missing first, stray lasts
				n = pick_size();
				push_key(n, 9'($urandom_range(0, 511)), $urandom_range(0, 2) != 0, 1'b1);
			end
			count += n;
		end
	endtask

	task automatic drain();
		do
			@(posedge clk);
		while (key_queue.size() != 0 || key_in.valid || hash_expected.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic reg_access(input logic [2:0] addr, input logic [31:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== val) begin
			$error("prdata: expected %h, actual %h", val, prdata);
			mismatches++;
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_config(input logic [31:0] seed, input bit fold);
		reg_access(ADDR_SEED, seed);
		reg_access(ADDR_FOLD, 32'(fold));
		cfg_seed = seed;
		cfg_fold = fold;
	endtask

	initial begin
		arst_n              = 1'b0;
		psel                = 1'b0;
		penable             = 1'b0;
		pwrite              = 1'b0;
		paddr               = '0;
		pwdata              = '0;
		key_in.valid        = 1'b0;
		key_in.data_byte    = '0;
		key_in.key_length   = '0;
		key_in.first_item   = 1'b0;
		key_in.last_item    = 1'b0;
		hash_out.ready      = 1'b0;
		cfg_seed            = SEED_RESET;
		cfg_fold            = FOLD_RESET;
		ln_a                = '0;
		ln_b                = '0;
		ln_c                = '0;
		slot                = '0;
		taken               = 0;
		blk_full            = 1'b0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// directed, reset register values
		push_item(8'h41, 9'd0, 1'b0, 1'b1);       // no first item after reset
		push_item(8'h00, 9'd0, 1'b1, 1'b1);       // empty key
		push_item(8'hff, 9'd0, 1'b1, 1'b0);       // empty start, then bytes
		push_item(8'h5a, 9'h1ff, 1'b0, 1'b1);
		push_item(8'h40, 9'h1ff, 1'b1, 1'b0);     // length disagrees with byte count
		push_item(8'h41, 9'd0, 1'b0, 1'b0);
		push_item(8'h5a, 9'd0, 1'b0, 1'b0);
		push_item(8'h5b, 9'd0, 1'b0, 1'b0);
		push_item(8'h7a, 9'd0, 1'b0, 1'b1);
		push_item(8'hff, 9'd0, 1'b0, 1'b1);       // extends the key after its last
		push_item(8'h80, 9'd1, 1'b1, 1'b1);
		for (int i = 0; i < BLOCK_LEN; i++)       // one full block, no mix
			push_item(8'(i * 21 + 3), 9'd12, i == 0, i == BLOCK_LEN - 1);
		drain();

		set_config(32'h0000_0000, 1'b0);
		random_keys(RAND_ITEMS);
		drain();

		set_config(32'hffff_ffff, 1'b1);
		push_key(515, 9'h1ff, 1'b1, 1'b0);        // bytes past the limit are dropped
		random_keys(RAND_ITEMS);
		drain();

		// back-to-back requests against a long result hold-off
		set_config($urandom(), 1'b0);
		quiet = 1'b1;
		random_keys(RAND_ITEMS);
		hold_req = ~hold_req;
		drain();
		quiet = 1'b0;

		set_config($urandom(), 1'b1);
		random_keys(RAND_ITEMS);
		drain();

		set_config(32'hffff_ffff, 1'b0);
		random_keys(RAND_ITEMS);
		drain();

		if (mismatches == 0 && hash_expected.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
